[design/latched_fault_code_table_defines.svh]
// assertion macros for the latched fault code table checker
// expects clk and rst_n in the scope where a macro is used
`ifndef LATCHED_FAULT_CODE_TABLE_DEFINES_SVH
`define LATCHED_FAULT_CODE_TABLE_DEFINES_SVH

// same-cycle implication
`define LFCT_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LFCT_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/lfct_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the latched fault code table
// no dependencies
package lfct_pkg;

  localparam int unsigned MAX_FAULTS = 16;
  localparam int unsigned IDX_W      = $clog2(MAX_FAULTS);
  localparam int unsigned CNT_W      = $clog2(MAX_FAULTS + 1);

  // job queue between front and back, depth a power of two
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_RAISE = 2'd0;
  localparam cmd_t CMD_CLEAR = 2'd1;
  localparam cmd_t CMD_READ  = 2'd2;
  localparam cmd_t CMD_SPARE = 2'd3;

  typedef logic [2:0] kind_t;
  localparam kind_t KIND_RAISE  = 3'd0;
  localparam kind_t KIND_CLEAR  = 3'd1;
  localparam kind_t KIND_READ   = 3'd2;
  localparam kind_t KIND_REJECT = 3'd3;
  localparam kind_t KIND_NOP    = 3'd4;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_RANGE = 2'd2;

  typedef struct packed {
    logic [2:0]  pad;
    logic [3:0]  read_index;
    logic [31:0] now_seconds;
    logic [63:0] detail_text;
    logic        detail_given;
    logic [63:0] fault_key;
  } in_data_t;

  typedef struct packed {
    logic [2:0]  pad;
    logic [63:0] entry_detail;
    logic [63:0] entry_key;
    logic [31:0] last_seen;
    logic [31:0] first_seen;
    logic [31:0] hit_count;
    logic        persist_request;
    logic        was_new;
    logic [3:0]  slot;
    logic [4:0]  fill_count;
    status_t     status;
  } res_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] key;
    logic        given;
    logic [63:0] detail;
    logic [31:0] now;
    logic [3:0]  ridx;
  } job_t;

  typedef struct packed {
    logic [63:0] key;
    logic [63:0] detail;
    logic [31:0] first;
    logic [31:0] last;
    logic [31:0] count;
  } entry_t;

endpackage

[design/lfct_front.sv]
`timescale 1ns / 1ps
// input side: takes command beats and classifies them into jobs
// depends on lfct_pkg
module lfct_front import lfct_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [167:0] in_tdata,  // fault_key, detail_given, detail_text, now_seconds, read_index
  input  logic [1:0]   in_tuser,  // cmd
  input  logic         q_full,
  output logic         q_push,
  output job_t         q_job
);

  in_data_t d;
  kind_t    kind;

  assign d = in_data_t'(in_tdata);

  always_comb begin
    unique case (in_tuser)
      CMD_RAISE: kind = (d.fault_key == 64'd0) ? KIND_REJECT : KIND_RAISE;
      CMD_CLEAR: kind = KIND_CLEAR;
      CMD_READ:  kind = KIND_READ;
      CMD_SPARE: kind = KIND_NOP;
      default:   kind = KIND_NOP;
    endcase
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  always_comb begin
    q_job.kind   = kind;
    q_job.key    = d.fault_key;
    q_job.given  = d.detail_given;
    q_job.detail = d.detail_text;
    q_job.now    = d.now_seconds;
    q_job.ridx   = d.read_index;
  end

endmodule

[design/lfct_queue.sv]
`timescale 1ns / 1ps
// short job queue between front and back
// depends on lfct_pkg
module lfct_queue import lfct_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic nonempty,
  output job_t head_job
);

  job_t               q_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0]  cnt_r;
  logic               do_push;
  logic               do_pop;

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign nonempty = (cnt_r != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign head_job = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

[design/lfct_back.sv]
`timescale 1ns / 1ps
// execution side: entry memory, key scan sequencer and result register
// depends on lfct_pkg
module lfct_back import lfct_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_valid,
  input  job_t         q_job,
  output logic         q_pop,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [239:0] out_tdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_RDW  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]            state_r, state_nxt;
  job_t                  cur_r, cur_nxt;
  logic [CNT_W-1:0]      filled_r, filled_nxt;
  logic [MAX_FAULTS-1:0] mask_r, mask_nxt;
  logic [CNT_W-1:0]      scan_r, scan_nxt;
  logic                  chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]      chk_idx_r, chk_idx_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic                  fresh_r, fresh_nxt;
  entry_t                ent_r, ent_nxt;
  res_t                  res_r, res_nxt;
  logic                  out_vld_r, out_vld_nxt;
  res_t                  out_r, out_nxt;

  entry_t                mem_r [MAX_FAULTS];
  entry_t                rd_data_r;
  logic [IDX_W-1:0]      rd_addr;
  logic                  wr_en;
  entry_t                wr_data;
  logic                  persist;

  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
    if (wr_en) begin
      mem_r[idx_r] <= wr_data;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    filled_nxt  = filled_r;
    mask_nxt    = mask_r;
    scan_nxt    = scan_r;
    chk_vld_nxt = chk_vld_r;
    chk_idx_nxt = chk_idx_r;
    idx_nxt     = idx_r;
    fresh_nxt   = fresh_r;
    ent_nxt     = ent_r;
    res_nxt     = res_r;
    out_nxt     = out_r;
    out_vld_nxt = out_vld_r && !out_tready;
    q_pop       = 1'b0;
    rd_addr     = scan_r[IDX_W-1:0];
    wr_en       = 1'b0;
    wr_data     = ent_r;
    persist     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cur_nxt   = q_job;
          state_nxt = S_DISP;
        end
      end

      S_DISP: begin
        res_nxt            = '0;
        res_nxt.fill_count = filled_r;
        unique case (cur_r.kind)
          KIND_RAISE: begin
            if (filled_r == '0) begin
              fresh_nxt = 1'b1;
              idx_nxt   = '0;
              state_nxt = S_UPD;
            end else begin
              scan_nxt    = '0;
              chk_vld_nxt = 1'b0;
              state_nxt   = S_SCAN;
            end
          end
          KIND_CLEAR: begin
            filled_nxt              = '0;
            mask_nxt                = '0;
            res_nxt.fill_count      = '0;
            res_nxt.persist_request = 1'b1;
            state_nxt               = S_FIN;
          end
          KIND_READ: begin
            res_nxt.slot = cur_r.ridx;
            if (CNT_W'(cur_r.ridx) >= filled_r) begin
              res_nxt.status = ST_RANGE;
              state_nxt      = S_FIN;
            end else begin
              rd_addr   = cur_r.ridx;
              state_nxt = S_RDW;
            end
          end
          KIND_REJECT: begin
            res_nxt.status = ST_EMPTY;
            state_nxt      = S_FIN;
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end

      // one read issued per cycle, compare runs one slot behind
      S_SCAN: begin
        if (chk_vld_r && rd_data_r.key == cur_r.key) begin
          ent_nxt   = rd_data_r;
          idx_nxt   = chk_idx_r;
          fresh_nxt = 1'b0;
          state_nxt = S_UPD;
        end else if (chk_vld_r && (CNT_W'(chk_idx_r) + CNT_W'(1) == filled_r)) begin
          fresh_nxt = 1'b1;
          idx_nxt   = (filled_r == CNT_W'(MAX_FAULTS)) ? IDX_W'(MAX_FAULTS - 1)
                                                        : filled_r[IDX_W-1:0];
          state_nxt = S_UPD;
        end else begin
          rd_addr     = scan_r[IDX_W-1:0];
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = scan_r[IDX_W-1:0];
          scan_nxt    = scan_r + CNT_W'(1);
        end
      end

      S_UPD: begin
        if (fresh_r) begin
          wr_data.key    = cur_r.key;
          wr_data.first  = cur_r.now;
          wr_data.count  = 32'd1;
          wr_data.detail = cur_r.given ? cur_r.detail : 64'd0;
        end else begin
          wr_data.key    = ent_r.key;
          wr_data.first  = ent_r.first;
          wr_data.count  = ent_r.count + 32'd1;
          wr_data.detail = cur_r.given ? cur_r.detail : ent_r.detail;
        end
        wr_data.last    = cur_r.now;
        wr_en           = 1'b1;
        persist         = fresh_r || !mask_r[idx_r];
        mask_nxt[idx_r] = 1'b1;
        if (fresh_r && filled_r != CNT_W'(MAX_FAULTS)) begin
          filled_nxt = filled_r + CNT_W'(1);
        end
        res_nxt.status          = ST_OK;
        res_nxt.fill_count      = filled_nxt;
        res_nxt.slot            = idx_r;
        res_nxt.was_new         = fresh_r;
        res_nxt.persist_request = persist;
        res_nxt.hit_count       = wr_data.count;
        res_nxt.first_seen      = wr_data.first;
        res_nxt.last_seen       = wr_data.last;
        res_nxt.entry_key       = wr_data.key;
        res_nxt.entry_detail    = wr_data.detail;
        state_nxt               = S_FIN;
      end

      S_RDW: begin
        res_nxt.hit_count    = rd_data_r.count;
        res_nxt.first_seen   = rd_data_r.first;
        res_nxt.last_seen    = rd_data_r.last;
        res_nxt.entry_key    = rd_data_r.key;
        res_nxt.entry_detail = rd_data_r.detail;
        state_nxt            = S_FIN;
      end

      S_FIN: begin
        if (!out_vld_r || out_tready) begin
          out_nxt     = res_r;
          out_vld_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      filled_r  <= '0;
      mask_r    <= '0;
      chk_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      filled_r  <= filled_nxt;
      mask_r    <= mask_nxt;
      chk_vld_r <= chk_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    scan_r    <= scan_nxt;
    chk_idx_r <= chk_idx_nxt;
    idx_r     <= idx_nxt;
    fresh_r   <= fresh_nxt;
    ent_r     <= ent_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r;

endmodule

[design/latched_fault_code_table.sv]
`timescale 1ns / 1ps
// top level of the latched fault code table: front, job queue and back
// depends on lfct_pkg, lfct_front, lfct_queue, lfct_back
//
// Holds up to 16 latched fault entries in one 16-entry memory with a single
// read port and registered read data. One command beat is worked on at a
// time; a two-deep job queue keeps the input open while the back is busy or
// a result waits in the output register. A raise scans the filled slots one
// per cycle through that read port. After reset the table is empty and ready
// at once: entries are only ever read below the fill count, so the memory
// needs no clearing pass.
module latched_fault_code_table import lfct_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [167:0] in_tdata,   // fault_key, detail_given, detail_text, now_seconds,
                                   // read_index, zero pad
  input  logic [1:0]   in_tuser,   // cmd
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [239:0] out_tdata   // status, fill_count, slot, was_new, persist_request,
                                   // hit_count, first_seen, last_seen, entry_key,
                                   // entry_detail, zero pad
);

  logic q_full;
  logic q_push;
  job_t q_in_job;
  logic q_pop;
  logic q_nonempty;
  job_t q_head_job;

  lfct_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_in_job)
  );

  lfct_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_in_job),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .head_job (q_head_job)
  );

  lfct_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_nonempty),
    .q_job      (q_head_job),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[design/lfct_checker.sv]
`timescale 1ns / 1ps
// port-level checks on the latched fault code table, bound to the top level
// depends on lfct_pkg and latched_fault_code_table_defines.svh
`include "latched_fault_code_table_defines.svh"

module lfct_checker import lfct_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [239:0] out_tdata
);

  res_t res;

  assign res = res_t'(out_tdata);

  `LFCT_ASSERT_IMP(a_fill_range, out_tvalid, res.fill_count <= CNT_W'(MAX_FAULTS), "fill count above table size")
  `LFCT_ASSERT_IMP(a_new_persists, out_tvalid && res.was_new, res.persist_request && res.status == ST_OK, "new entry without persist request")
  `LFCT_ASSERT_IMP(a_range_empty, out_tvalid && res.status == ST_RANGE, res.entry_key == '0 && res.hit_count == '0 && !res.persist_request, "out of range read carries entry data")
  `LFCT_ASSERT_NXT(a_result_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result beat changed")

endmodule

bind latched_fault_code_table lfct_checker u_lfct_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
